[src/fhsp_pkg.sv]
// Package: types, constants and codes for the floating horizon segment plotter.
`default_nettype none
package fhsp_pkg;
   localparam int MaxColumns    = 2048;
   localparam int MaxSteps      = 64;
   localparam int CoordFracBits = 4;
   localparam int WalkFrac      = 16;
   localparam int ColBits       = $clog2(MaxColumns);
   localparam int StepBits      = $clog2(MaxSteps + 1);
   localparam int HorBits       = 16;

   localparam logic [1:0] STATUS_IN_FIELD = 2'd0;
   localparam logic [1:0] STATUS_LEFT     = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

   localparam logic CMD_DRAW  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   localparam logic [0:0] CSR_FIELD_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_FIELD_HEIGHT = 1'b1;

   typedef struct packed {
      logic               command;
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
      logic signed [15:0] end_x;
      logic signed [15:0] end_y;
   } req_type;

   typedef struct packed {
      logic [10:0] pixel_x;
      logic [10:0] pixel_y;
      logic        plotted;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_SETUP, ST_DIVX, ST_DIVY, ST_SIGN,
      ST_CHECK, ST_READ, ST_UPDATE, ST_OUT
   } state_type;
endpackage
`default_nettype wire

[src/floating_horizon_segment_plotter_top.sv]
// Top level: sequencer, DDA walk and horizon memories of the segment plotter.
// Clear: writes every column of both horizons, no results. Draw: setup after the
// accepting edge (setup, two serial divisions, sign fix; setup alone for zero length),
// then per step a horizon read-modify-write (check, read, update, output) plus stalls;
// <= 64 steps. One item at a time; req_stall stays high until the last beat is taken.
// Synchronous active-high reset restores field size 1150x680; horizons are undefined.
`default_nettype none
module floating_horizon_segment_plotter_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire fhsp_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output fhsp_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_index,
   input  wire logic [11:0]       csr_wdata
);
   import fhsp_pkg::*;

   localparam int Scale = WalkFrac - CoordFracBits;

   state_type state_ff, state_in;
   logic [11:0] fw_ff, fh_ff;

   logic signed [15:0] sx_ff, sy_ff, sx_in, sy_in;
   logic [16:0] dx_ff, ady_ff, len_ff, dx_in, ady_in, len_in;
   logic        dyneg_ff, dyneg_in;
   logic [StepBits-1:0] steps_ff, steps_in, idx_ff, idx_in;
   logic signed [33:0] x_ff, y_ff, x_in, y_in;
   logic signed [33:0] incx_ff, incy_ff, incx_in, incy_in;
   logic [ColBits-1:0] col_ff, col_in;
   logic [10:0] py_ff, py_in;
   logic [HorBits-1:0] yq_ff, yq_in;
   logic [ColBits:0] clr_ff, clr_in;
   rsp_type out_ff, out_in;
   logic        outv_ff, outv_in;

   // horizon memories
   logic [HorBits-1:0] upper_mem [MaxColumns];
   logic [HorBits-1:0] lower_mem [MaxColumns];
   logic [HorBits-1:0] up_rd_ff, lo_rd_ff;
   logic               up_we, lo_we;
   logic [ColBits-1:0] wr_addr;
   logic [HorBits-1:0] up_wd, lo_wd;

   logic        div_start, div_done;
   logic [32:0] div_dividend, div_q;

   fhsp_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(len_ff), .done(div_done), .quotient(div_q)
   );

   // setup arithmetic
   logic signed [15:0] ax, ay, bx, by;
   logic signed [16:0] dxs, dys;
   logic [16:0] ady_c;
   always_comb begin
      if (req_data.start_x > req_data.end_x) begin
         ax = req_data.end_x;   ay = req_data.end_y;
         bx = req_data.start_x; by = req_data.start_y;
      end else begin
         ax = req_data.start_x; ay = req_data.start_y;
         bx = req_data.end_x;   by = req_data.end_y;
      end
      dxs   = 17'(bx) - 17'(ax);
      dys   = 17'(by) - 17'(ay);
      ady_c = dys[16] ? 17'(-dys) : 17'(dys);
   end

   // step arithmetic
   logic signed [33:0] xr;
   logic [33:0] xmag;
   logic [17:0] pxmag;
   logic        px_neg, in_field;
   logic [12:0] width_eff;
   always_comb begin
      px_neg = x_ff[33];
      xmag   = px_neg ? 34'(-x_ff) : 34'(x_ff);
      xr     = signed'(xmag + 34'(1 << (WalkFrac - 1)));
      pxmag  = 18'(xr >>> WalkFrac);
      width_eff = (fw_ff > 12'(MaxColumns - 1)) ? 13'(MaxColumns) : 13'(fw_ff);
      in_field = (!px_neg || pxmag == 18'd0) && ({1'b0, pxmag} < 19'(width_eff))
                 && !y_ff[33] && (y_ff < signed'({6'd0, fh_ff, 16'd0}));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) begin
            if (req_data.command == CMD_CLEAR) state_in = ST_CLEAR;
            else state_in = ST_SETUP;
         end
         ST_CLEAR: if (clr_ff == (ColBits+1)'(MaxColumns - 1)) state_in = ST_IDLE;
         ST_SETUP: begin
            if (steps_ff > StepBits'(MaxSteps)) state_in = ST_OUT;
            else if (len_ff == 17'd0) state_in = ST_CHECK;
            else state_in = ST_DIVX;
         end
         ST_DIVX: if (div_done) state_in = ST_DIVY;
         ST_DIVY: if (div_done) state_in = ST_SIGN;
         ST_SIGN:   state_in = ST_CHECK;
         ST_CHECK:  state_in = in_field ? ST_READ : ST_OUT;
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_OUT;
         ST_OUT: if (!rsp_stall) begin
            if (out_ff.last) state_in = ST_IDLE;
            else state_in = ST_CHECK;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath
   logic [16:0] steps_w;
   always_comb begin
      sx_in = sx_ff; sy_in = sy_ff; dx_in = dx_ff; ady_in = ady_ff; len_in = len_ff;
      dyneg_in = dyneg_ff; steps_in = steps_ff; idx_in = idx_ff;
      x_in = x_ff; y_in = y_ff; incx_in = incx_ff; incy_in = incy_ff;
      col_in = col_ff; py_in = py_ff; yq_in = yq_ff; clr_in = clr_ff;
      out_in = out_ff; outv_in = 1'b0;
      div_start = 1'b0; div_dividend = {dx_ff, 16'd0};
      up_we = 1'b0; lo_we = 1'b0; wr_addr = col_ff; up_wd = yq_ff; lo_wd = yq_ff;
      steps_w = '0;
      case (state_ff)
         ST_IDLE: if (req_valid) begin
            sx_in = ax; sy_in = ay;
            dx_in = 17'(dxs); ady_in = ady_c; dyneg_in = dys[16];
            len_in = (17'(dxs) > ady_c) ? 17'(dxs) : ady_c;
            steps_w = (((17'(dxs) > ady_c) ? 17'(dxs) : ady_c) >> CoordFracBits) + 17'd1;
            steps_in = (steps_w > 17'(MaxSteps)) ? StepBits'(MaxSteps + 1)
                                                  : StepBits'(steps_w);
            clr_in = '0; idx_in = '0;
            incx_in = '0; incy_in = '0;
         end
         ST_CLEAR: begin
            up_we = 1'b1; lo_we = 1'b1; wr_addr = clr_ff[ColBits-1:0];
            up_wd = '0; lo_wd = HorBits'({fh_ff, CoordFracBits'(0)});
            clr_in = clr_ff + 1'b1;
         end
         ST_SETUP: begin
            x_in = 34'(sx_ff) <<< Scale;
            y_in = 34'(sy_ff) <<< Scale;
            if (steps_ff > StepBits'(MaxSteps)) begin
               out_in = '{pixel_x: '0, pixel_y: '0, plotted: 1'b0,
                          status: STATUS_TOO_LONG, last: 1'b1};
               outv_in = 1'b1;
            end else if (len_ff != 17'd0) begin
               div_start = 1'b1; div_dividend = {dx_ff, 16'd0};
            end
         end
         ST_DIVX: if (div_done) begin
            incx_in = 34'(div_q);
            div_start = 1'b1; div_dividend = {ady_ff, 16'd0};
         end
         ST_DIVY: if (div_done) incy_in = 34'(div_q);
         ST_SIGN: if (dyneg_ff) incy_in = -incy_ff;
         ST_CHECK: begin
            col_in = ColBits'(pxmag);
            py_in  = 11'(y_ff >>> WalkFrac);
            yq_in  = HorBits'(y_ff >>> Scale);
            if (!in_field) begin
               out_in = '{pixel_x: '0, pixel_y: '0, plotted: 1'b0,
                          status: STATUS_LEFT, last: 1'b1};
               outv_in = 1'b1;
            end
         end
         ST_UPDATE: begin
            out_in.pixel_x = 11'(col_ff);
            out_in.pixel_y = py_ff;
            out_in.status  = STATUS_IN_FIELD;
            out_in.last    = (idx_ff + 1'b1) == steps_ff;
            out_in.plotted = 1'b0;
            if (yq_ff > up_rd_ff) begin
               up_we = 1'b1; out_in.plotted = 1'b1;
            end else if (yq_ff < lo_rd_ff) begin
               lo_we = 1'b1; out_in.plotted = 1'b1;
            end
            outv_in = 1'b1;
            idx_in = idx_ff + 1'b1;
            x_in = x_ff + incx_ff;
            y_in = y_ff + incy_ff;
         end
         ST_OUT: outv_in = rsp_stall;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (up_we) upper_mem[wr_addr] <= up_wd;
      if (lo_we) lower_mem[wr_addr] <= lo_wd;
      up_rd_ff <= upper_mem[col_ff];
      lo_rd_ff <= lower_mem[col_ff];
   end

   always_ff @(posedge clock) begin
      sx_ff <= sx_in; sy_ff <= sy_in; dx_ff <= dx_in; ady_ff <= ady_in; len_ff <= len_in;
      dyneg_ff <= dyneg_in; steps_ff <= steps_in; idx_ff <= idx_in;
      x_ff <= x_in; y_ff <= y_in; incx_ff <= incx_in; incy_ff <= incy_in;
      col_ff <= col_in; py_ff <= py_in; yq_ff <= yq_in; clr_ff <= clr_in;
      out_ff <= out_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         outv_ff  <= 1'b0;
         fw_ff    <= 12'd1150;
         fh_ff    <= 12'd680;
      end else begin
         state_ff <= state_in;
         outv_ff  <= outv_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_FIELD_WIDTH) fw_ff <= csr_wdata;
            else fh_ff <= csr_wdata;
         end
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = outv_ff;
   assign rsp_data  = out_ff;
   assign csr_ready = 1'b1;

   property p_valid_in_out;
      @(posedge clock) disable iff (reset) rsp_valid |-> (state_ff == ST_OUT);
   endproperty
   a_valid_in_out: assert property (p_valid_in_out) else $error("result beat outside output state");

   property p_idx_bound;
      @(posedge clock) disable iff (reset) (state_ff == ST_CHECK) |-> (idx_ff < steps_ff);
   endproperty
   a_idx_bound: assert property (p_idx_bound) else $error("step index past count");

   property p_idle_after_last;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_stall && rsp_data.last) |=> (state_ff == ST_IDLE);
   endproperty
   a_idle_after_last: assert property (p_idle_after_last) else $error("no idle after last beat");
endmodule
`default_nettype wire

[src/fhsp_divider.sv]
// Restoring divider: 33-bit dividend by 17-bit divisor, one quotient bit per cycle.
`default_nettype none
module fhsp_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [32:0] dividend,
   input  wire logic [16:0] divisor,
   output logic             done,
   output logic [32:0]      quotient
);
   import fhsp_pkg::*;

   logic [32:0] quot_ff, quot_in;
   logic [17:0] rem_ff, rem_in;
   logic [16:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [17:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[16:0], quot_ff[32]};
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = 6'd33;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = trial - {1'b0, den_ff};
            quot_in = {quot_ff[31:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

   property p_done_after_busy;
      @(posedge clock) disable iff (reset) done_ff |-> $past(busy_ff);
   endproperty
   a_done_after_busy: assert property (p_done_after_busy) else $error("done without busy");

   property p_cnt_zero_idle;
      @(posedge clock) disable iff (reset) (busy_ff && !start) |-> (cnt_ff != 6'd0);
   endproperty
   a_cnt_zero_idle: assert property (p_cnt_zero_idle) else $error("busy with zero count");

   property p_rem_bound;
      @(posedge clock) disable iff (reset) (busy_ff && !start) |=> (rem_ff < {1'b0, den_ff});
   endproperty
   a_rem_bound: assert property (p_rem_bound) else $error("remainder out of range");
endmodule
`default_nettype wire

[dv/tb.sv]
// Testbench for the floating horizon segment plotter: directed and random segments checked per beat.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fhsp_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = 1'b0;
   logic [11:0] csr_wdata = '0;

   floating_horizon_segment_plotter_top dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [11:0] fld_w, fld_h;
   logic [15:0] upper_hor [MaxColumns];
   logic [15:0] lower_hor [MaxColumns];
   bit cleared;
   rsp_type pixel_q[$];
   int errors = 0;
   bit idle_en = 1'b0;
   int hold_cycles = 0;

   function automatic rsp_type mk(logic [10:0] px, logic [10:0] py, logic pl,
                                  logic [1:0] st, logic ls);
      rsp_type r;
      r.pixel_x = px; r.pixel_y = py; r.plotted = pl; r.status = st; r.last = ls;
      return r;
   endfunction

   function automatic void queue_beat(rsp_type b);
      pixel_q.insert(pixel_q.size(), b);
   endfunction

   task automatic predict_walk(req_type r);
      longint sx, sy, ex, ey, t, dx, dy, ady, len, steps, incx, incy, x, y, px;
      longint width, ylimit;
      logic [31:0] yq;
      logic pl;
      int col;
      if (r.command == CMD_CLEAR) begin
         for (int i = 0; i < MaxColumns; i++) begin
            upper_hor[i] = '0;
            lower_hor[i] = 16'(fld_h << CoordFracBits);
         end
         cleared = 1'b1;
         return;
      end
      sx = r.start_x; sy = r.start_y; ex = r.end_x; ey = r.end_y;
      if (sx > ex) begin
         t = sx; sx = ex; ex = t;
         t = sy; sy = ey; ey = t;
      end
      dx = ex - sx; dy = ey - sy;
      ady = dy < 0 ? -dy : dy;
      len = dx > ady ? dx : ady;
      steps = (len >>> CoordFracBits) + 1;
      if (steps > MaxSteps) begin
         queue_beat(mk('0, '0, 1'b0, STATUS_TOO_LONG, 1'b1));
         return;
      end
      incx = 0; incy = 0;
      if (len != 0) begin
         incx = (dx <<< WalkFrac) / len;
         incy = (ady <<< WalkFrac) / len;
         if (dy < 0) incy = -incy;
      end
      x = sx <<< (WalkFrac - CoordFracBits);
      y = sy <<< (WalkFrac - CoordFracBits);
      width = fld_w > MaxColumns ? MaxColumns : fld_w;
      ylimit = longint'(fld_h) <<< WalkFrac;
      for (longint i = 0; i < steps; i++) begin
         if (x >= 0) px = (x + (1 <<< (WalkFrac - 1))) >>> WalkFrac;
         else px = -((-x + (1 <<< (WalkFrac - 1))) >>> WalkFrac);
         if (px < 0 || px >= width || y < 0 || y >= ylimit) begin
            queue_beat(mk('0, '0, 1'b0, STATUS_LEFT, 1'b1));
            return;
         end
         yq = 32'(y >>> (WalkFrac - CoordFracBits));
         col = int'(px);
         pl = 1'b0;
         if (yq > upper_hor[col]) begin
            upper_hor[col] = yq[15:0]; pl = 1'b1;
         end else if (yq < lower_hor[col]) begin
            lower_hor[col] = yq[15:0]; pl = 1'b1;
         end
         queue_beat(mk(11'(px), 11'(y >>> WalkFrac), pl, STATUS_IN_FIELD,
                       i + 1 == steps));
         x += incx; y += incy;
      end
   endtask

   // receiver: random stall plus a long hold-off when asked
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else
         rsp_stall <= idle_en && ($urandom_range(99) < 11);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_q.size() == 0) begin
            $error("unexpected beat %p", rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = pixel_q.pop_front();
            if (rsp_data.pixel_x !== e.pixel_x) begin
               $error("pixel_x exp %0d got %0d", e.pixel_x, rsp_data.pixel_x); errors++;
            end
            if (rsp_data.pixel_y !== e.pixel_y) begin
               $error("pixel_y exp %0d got %0d", e.pixel_y, rsp_data.pixel_y); errors++;
            end
            if (rsp_data.plotted !== e.plotted) begin
               $error("plotted exp %0d got %0d", e.plotted, rsp_data.plotted); errors++;
            end
            if (rsp_data.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_data.status); errors++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_data.last); errors++;
            end
         end
      end
   end

   task automatic send_item(req_type r);
      while (idle_en && $urandom_range(99) < 11) @(posedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      predict_walk(r);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_seg(int sx, int sy, int ex, int ey);
      req_type r;
      r.command = CMD_DRAW;
      r.start_x = 16'(sx); r.start_y = 16'(sy); r.end_x = 16'(ex); r.end_y = 16'(ey);
      send_item(r);
   endtask

   task automatic send_clear();
      req_type r;
      r = '0;
      r.command = CMD_CLEAR;
      r.start_x = 16'($urandom); r.end_y = 16'($urandom);
      send_item(r);
   endtask

   // wait for every beat and for the block to go idle
   task automatic drain();
      while (pixel_q.size() != 0 || req_stall) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [11:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_FIELD_WIDTH) fld_w = val; else fld_h = val;
      @(posedge clock);
   endtask

   task automatic set_field(logic [11:0] w, logic [11:0] h);
      drain();
      csr_write(CSR_FIELD_WIDTH, w);
      csr_write(CSR_FIELD_HEIGHT, h);
      send_clear();
   endtask

   task automatic test_directed();
      send_clear();
      send_seg(0, 0, 0, 0);                     // zero length
      send_seg(160, 160, 160, 160);
      send_seg(100, 500, 900, 100);
      send_seg(900, 100, 100, 500);             // swapped ends
      send_seg(50, 50, 50, 1000);               // vertical
      send_seg(50, 1000, 50, 50);
      send_seg(0, 0, 1008, 0);                  // 64 steps
      send_seg(0, 0, 1024, 0);                  // too long
      send_seg(-32768, -32768, 32767, 32767);
      send_seg(32767, 32767, 32767, 32767);
      send_seg(-32768, 0, -32768, 0);
      send_seg(-16, 100, 200, 100);             // starts out of field
      send_seg(18390, 100, 18500, 100);         // leaves on the right
      send_seg(100, 10870, 100, 10900);         // leaves at the bottom
      send_seg(200, 300, 300, 200);
      send_seg(8, 8, 7, 7);
   endtask

   function automatic int rc(int lim);
      return $urandom_range(2 * lim) - lim;
   endfunction

   task automatic test_random(int n, int span);
      int sx, sy;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 4) send_clear();
         else if ($urandom_range(99) < 8) begin
            req_type r;
            r = '0;
            r.command = CMD_DRAW;
            r.start_x = 16'($urandom); r.start_y = 16'($urandom);
            r.end_x = 16'($urandom); r.end_y = 16'($urandom);
            send_item(r);
         end else begin
            sx = $urandom_range(span); sy = $urandom_range(span);
            send_seg(sx, sy, sx + rc(700), sy + rc(700));
         end
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 3000;
      for (int i = 0; i < 6; i++) send_seg(100 + 40 * i, 200, 600, 400 + 30 * i);
      drain();
      send_seg(300, 300, 800, 900);
   endtask

   initial begin
      fld_w = 12'd1150; fld_h = 12'd680; cleared = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(60, 20000);          // no idling here
      idle_en = 1'b1;
      test_random(60, 20000);
      set_field(12'd2048, 12'd2048);
      test_random(40, 34000);
      set_field(12'd1, 12'd1);
      send_seg(0, 0, 0, 0);
      send_seg(0, 0, 8, 8);
      test_random(10, 40);
      set_field(12'd0, 12'd0);
      send_seg(0, 0, 0, 0);
      send_seg(16, 16, 16, 16);
      set_field(12'd4095, 12'd4095);
      test_random(30, 32767);
      set_field(12'd37, 12'd29);
      test_random(40, 600);
      test_backpressure();
      drain();
      if (errors == 0 && pixel_q.size() == 0)
         $display("floating_horizon_segment_plotter_top verification clean");
      else
         $display("floating_horizon_segment_plotter_top verification failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("floating_horizon_segment_plotter_top verification failed");
      $finish;
   end
endmodule
`default_nettype wire

[filelist.f]
src/fhsp_pkg.sv
src/fhsp_divider.sv
src/floating_horizon_segment_plotter_top.sv
dv/tb.sv
